// File: hw/rtl/dca_pkg.sv
// Shared types and constants for the DMA channel allocator.
// No dependencies; imported by every module of the allocator.
package dca_pkg;

    localparam int CH_W             = 3;   // channel field width
    localparam int LIST_DEPTH       = 8;   // packet list entries per side
    localparam int CNT_W            = 4;   // holds 0..LIST_DEPTH
    localparam int CFG_IDX_W        = 4;
    localparam int CFG_DATA_W       = 4;
    localparam int MAX_CHANNELS_DEF = 8;
    localparam logic [CFG_DATA_W-1:0] CFG_COUNT_RESET = CFG_DATA_W'(2);

    localparam logic [CFG_IDX_W-1:0] CFG_PROD_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CONS_COUNT = CFG_IDX_W'(1);

    localparam logic CMD_FIND   = 1'b0;
    localparam logic CMD_ASSIGN = 1'b1;

    localparam logic SIDE_PROD = 1'b0;
    localparam logic SIDE_CONS = 1'b1;

    localparam logic [1:0] MODE_CIRCUIT = 2'd0;
    localparam logic [1:0] MODE_FIRST   = 2'd1;
    localparam logic [1:0] MODE_RR      = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GATHER,
        S_DECIDE,
        S_PURGE,
        S_DONE
    } t_state;

    // Control for one packet list chain.
    typedef struct packed {
        logic            shift;   // rotate one entry toward the head
        logic            keep;    // re-insert the departing head at the tail
        logic            append;  // write data at the tail, grow by one
        logic [CH_W-1:0] data;
    } t_chain_ctl;

endpackage

// File: hw/rtl/dca_cell.sv
// One packet list entry: holds a channel, takes its neighbor on shift.
// Depends on dca_pkg.
module dca_cell import dca_pkg::*; (
    input  logic            i_clk,
    input  logic            i_shift,
    input  logic [CH_W-1:0] i_nbr,
    input  logic            i_wr,
    input  logic [CH_W-1:0] i_wdata,
    output logic [CH_W-1:0] o_val
);

    logic [CH_W-1:0] r_val;
    logic [CH_W-1:0] n_val;

    always_comb begin
        n_val = r_val;
        if (i_wr) begin
            n_val = i_wdata;
        end else if (i_shift) begin
            n_val = i_nbr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

// File: hw/rtl/dca_chain.sv
// Packet list of one side: a row of dca_cell entries plus the fill count.
// Depends on dca_pkg and dca_cell.
module dca_chain import dca_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_chain_ctl       i_ctl,
    output logic [CH_W-1:0]  o_head,
    output logic [CNT_W-1:0] o_count
);

    logic [CH_W-1:0]  w_val [LIST_DEPTH];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             w_room;

    assign w_room = (r_count < CNT_W'(LIST_DEPTH));

    always_comb begin
        n_count = r_count;
        if (i_ctl.shift && !i_ctl.keep) begin
            n_count = r_count - CNT_W'(1);
        end else if (i_ctl.append && w_room) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        logic            w_wr;
        logic [CH_W-1:0] w_nbr;
        logic [CH_W-1:0] w_wdata;

        // head re-enters at the last occupied slot; append lands just past it
        assign w_wr = (i_ctl.shift && i_ctl.keep && (CNT_W'(g) == r_count - CNT_W'(1)))
                   || (i_ctl.append && w_room && (CNT_W'(g) == r_count));
        assign w_wdata = i_ctl.shift ? w_val[0] : i_ctl.data;

        if (g == LIST_DEPTH - 1) begin : g_last
            assign w_nbr = w_val[g];
        end else begin : g_mid
            assign w_nbr = w_val[g+1];
        end

        dca_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (i_ctl.shift),
            .i_nbr   (w_nbr),
            .i_wr    (w_wr),
            .i_wdata (w_wdata),
            .o_val   (w_val[g])
        );
    end

    assign o_head  = w_val[0];
    assign o_count = r_count;

endmodule

// File: hw/rtl/dma_channel_allocator_lru_top.sv
// DMA channel allocator, producer and consumer sides, first fit with LRU round robin.
// Unused mode goes straight to the result; other modes first rotate the list once;
// round robin, on a hit, then purges the chosen channel and appends it at the tail.
// One request in flight, paced by the list rotation; next beat taken the cycle after load.
// Reset (synchronous, i_rst_n low): masks and list counts zero, counts registers 2.
// Depends on dca_pkg, dca_chain, dca_cell.
module dma_channel_allocator_lru_top import dca_pkg::*; #(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_command,
    input  logic                  i_side,
    input  logic [1:0]            i_mode,
    input  logic [CH_W-1:0]       i_given_channel,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_found,
    output logic [CH_W-1:0]       o_chosen_channel,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int NCH = 1 << CH_W;   // channels the 3-bit field can name

    // ---------------- configuration registers ----------------
    logic [CFG_DATA_W-1:0] r_prod_cnt;
    logic [CFG_DATA_W-1:0] r_cons_cnt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_cnt <= CFG_COUNT_RESET;
            r_cons_cnt <= CFG_COUNT_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_PROD_COUNT) begin
                r_prod_cnt <= i_cfg_data;
            end else if (i_cfg_index == CFG_CONS_COUNT) begin
                r_cons_cnt <= i_cfg_data;
            end
        end
    end

    // ---------------- state ----------------
    t_state           r_state, n_state;
    logic             r_cmd, r_side;
    logic [1:0]       r_mode;
    logic [CH_W-1:0]  r_given;
    logic [CH_W-1:0]  r_ch,    n_ch;      // channel being recorded
    logic [NCH-1:0]   r_bits,  n_bits;    // channels held in the packet list
    logic [CNT_W-1:0] r_left,  n_left;    // entries still to rotate this pass
    logic             r_found, n_found;   // pending result
    logic [NCH-1:0]   r_pmask, n_pmask;
    logic [NCH-1:0]   r_cmask, n_cmask;
    logic             r_out_valid, n_out_valid;
    logic             r_res_found, n_res_found;
    logic [CH_W-1:0]  r_res_ch,    n_res_ch;

    // ---------------- packet list chains ----------------
    t_chain_ctl       w_ctl, w_ctl_p, w_ctl_c;
    logic [CH_W-1:0]  w_head_p, w_head_c, w_head;
    logic [CNT_W-1:0] w_cnt_p, w_cnt_c, w_cnt;

    assign w_ctl_p = (r_side == SIDE_PROD) ? w_ctl : '0;
    assign w_ctl_c = (r_side == SIDE_CONS) ? w_ctl : '0;

    dca_chain u_chain_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_p),
        .o_head  (w_head_p),
        .o_count (w_cnt_p)
    );

    dca_chain u_chain_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_c),
        .o_head  (w_head_c),
        .o_count (w_cnt_c)
    );

    // Side-selected views; r_side is stable from accept to done.
    logic [CNT_W-1:0] w_cnt_in;
    logic [NCH-1:0]   w_mask;
    logic [CFG_DATA_W-1:0] w_limit_raw;

    assign w_head      = r_side ? w_head_c : w_head_p;
    assign w_cnt       = r_side ? w_cnt_c  : w_cnt_p;
    assign w_cnt_in    = i_side ? w_cnt_c  : w_cnt_p;
    assign w_mask      = r_side ? r_cmask  : r_pmask;
    assign w_limit_raw = r_side ? r_cons_cnt : r_prod_cnt;

    // ---------------- channel choice (used in S_DECIDE) ----------------
    logic [NCH-1:0]  w_excl;
    logic            w_free_hit;
    logic [CH_W-1:0] w_free_ch;
    logic            w_sel_found;
    logic [CH_W-1:0] w_sel_ch;

    always_comb begin
        w_excl = w_mask | ((r_mode != MODE_FIRST) ? r_bits : '0);
        w_free_hit = 1'b0;
        w_free_ch  = '0;
        // scan high to low so the lowest eligible channel wins
        for (int i = NCH - 1; i >= 0; i--) begin
            if ((i < int'(w_limit_raw)) && (i < MAX_CHANNELS) && !w_excl[i]) begin
                w_free_hit = 1'b1;
                w_free_ch  = CH_W'(i);
            end
        end
        if (r_cmd == CMD_ASSIGN) begin
            w_sel_found = 1'b1;
            w_sel_ch    = r_given;
        end else if (w_free_hit) begin
            w_sel_found = 1'b1;
            w_sel_ch    = w_free_ch;
        end else if ((r_mode == MODE_RR) && (w_cnt != '0)) begin
            // nothing free: reuse the oldest packet channel
            w_sel_found = 1'b1;
            w_sel_ch    = w_head;
        end else begin
            w_sel_found = 1'b0;
            w_sel_ch    = '0;
        end
    end

    // ---------------- sequencer ----------------
    logic w_in_acc;
    logic w_load;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_ch        = r_ch;
        n_bits      = r_bits;
        n_left      = r_left;
        n_found     = r_found;
        n_pmask     = r_pmask;
        n_cmask     = r_cmask;
        w_ctl       = '0;
        w_load      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_bits  = '0;
                    n_left  = w_cnt_in;
                    n_found = 1'b0;
                    n_ch    = '0;
                    n_state = (i_mode == MODE_UNUSED) ? S_DONE : S_GATHER;
                end
            end
            S_GATHER: begin
                // full rotation collects list membership and restores order
                if (r_left != '0) begin
                    w_ctl.shift = 1'b1;
                    w_ctl.keep  = 1'b1;
                    n_bits      = r_bits | (NCH'(1) << w_head);
                    n_left      = r_left - CNT_W'(1);
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_found = w_sel_found;
                n_ch    = w_sel_found ? w_sel_ch : '0;
                n_state = S_DONE;
                if (w_sel_found) begin
                    unique case (r_mode)
                        MODE_CIRCUIT: begin
                            if (r_side == SIDE_CONS) begin
                                n_cmask = r_cmask | (NCH'(1) << w_sel_ch);
                            end else begin
                                n_pmask = r_pmask | (NCH'(1) << w_sel_ch);
                            end
                        end
                        MODE_FIRST: begin
                            w_ctl.append = !r_bits[w_sel_ch];
                            w_ctl.data   = w_sel_ch;
                        end
                        MODE_RR: begin
                            n_left  = w_cnt;
                            n_state = S_PURGE;
                        end
                        default: begin
                            n_found = 1'b0;
                            n_ch    = '0;
                        end
                    endcase
                end
            end
            S_PURGE: begin
                // drop the chosen channel wherever it sits, then append it
                if (r_left != '0) begin
                    w_ctl.shift = 1'b1;
                    w_ctl.keep  = (w_head != r_ch);
                    n_left      = r_left - CNT_W'(1);
                end else begin
                    w_ctl.append = 1'b1;
                    w_ctl.data   = r_ch;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register: holds a finished beat until taken
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_res_found = r_res_found;
        n_res_ch    = r_res_ch;
        if (w_load) begin
            n_out_valid = 1'b1;
            n_res_found = r_found;
            n_res_ch    = r_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pmask     <= '0;
            r_cmask     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pmask     <= n_pmask;
            r_cmask     <= n_cmask;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd   <= i_command;
            r_side  <= i_side;
            r_mode  <= i_mode;
            r_given <= i_given_channel;
        end
        r_ch        <= n_ch;
        r_bits      <= n_bits;
        r_left      <= n_left;
        r_found     <= n_found;
        r_res_found <= n_res_found;
        r_res_ch    <= n_res_ch;
    end

    assign o_out_valid      = r_out_valid;
    assign o_found          = r_res_found;
    assign o_chosen_channel = r_res_ch;

    // ---------------- assertions ----------------
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state != S_IDLE))
        else $error("request beat accepted but sequencer stayed idle");

    a_mask_only_in_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DECIDE) |=> ($stable(r_pmask) && $stable(r_cmask)))
        else $error("circuit mask changed outside the decide step");

    a_list_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cnt_p <= CNT_W'(LIST_DEPTH)) && (w_cnt_c <= CNT_W'(LIST_DEPTH)))
        else $error("packet list count beyond list depth");

    a_none_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (o_found || (o_chosen_channel == '0)))
        else $error("result without a channel carries a nonzero channel");

    a_idle_chain_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!w_ctl.shift && !w_ctl.append))
        else $error("packet list moved while idle");

endmodule

// File: dv/dca_checker.sv
`timescale 1ns / 1ps
// Grant checker for the DMA channel allocator: watches the request, result and
// register-write channels, predicts each grant and compares it. Depends on dca_pkg.
module dca_checker import dca_pkg::*; #(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic                  i_command,
    input  logic                  i_side,
    input  logic [1:0]            i_mode,
    input  logic [CH_W-1:0]       i_given_channel,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_found,
    input  logic [CH_W-1:0]       i_chosen_channel,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic            found;
        logic [CH_W-1:0] chan;
    } t_grant;

    t_grant                  pending_grants[$];

    // Shadow allocator state, indexed by side.
    logic [CFG_DATA_W-1:0]   chan_limit [2];
    logic [LIST_DEPTH-1:0]   circ_mask  [2];
    logic [CH_W-1:0]         pkt_order  [2][LIST_DEPTH];
    int                      pkt_len    [2];

    function automatic logic [LIST_DEPTH-1:0] list_members(int s);
        logic [LIST_DEPTH-1:0] m;
        m = '0;
        for (int k = 0; k < pkt_len[s]; k++) m[pkt_order[s][k]] = 1'b1;
        return m;
    endfunction

    function automatic void list_drop(int s, logic [CH_W-1:0] ch);
        int w;
        w = 0;
        for (int k = 0; k < pkt_len[s]; k++) begin
            if (pkt_order[s][k] != ch) begin
                pkt_order[s][w] = pkt_order[s][k];
                w++;
            end
        end
        pkt_len[s] = w;
    endfunction

    function automatic void list_push(int s, logic [CH_W-1:0] ch);
        logic [LIST_DEPTH-1:0] m;
        m = list_members(s);
        if (!m[ch] && pkt_len[s] < LIST_DEPTH) begin
            pkt_order[s][pkt_len[s]] = ch;
            pkt_len[s]++;
        end
    endfunction

    // Works out the grant for one request and records it in the shadow state.
    function automatic t_grant allocate(logic cmd, logic sd, logic [1:0] md,
                                        logic [CH_W-1:0] given);
        t_grant                g;
        int                    s;
        int                    lim;
        logic [LIST_DEPTH-1:0] excl;
        g = '0;
        s = int'(sd);
        if (md == MODE_UNUSED) return g;
        if (cmd == CMD_ASSIGN) begin
            g.found = 1'b1;
            g.chan  = given;
        end else begin
            lim = int'(chan_limit[s]);
            if (lim > MAX_CHANNELS) lim = MAX_CHANNELS;
            if (lim > LIST_DEPTH) lim = LIST_DEPTH;
            excl = circ_mask[s];
            if (md != MODE_FIRST) excl |= list_members(s);
            for (int i = 0; i < lim; i++) begin
                if (!g.found && !excl[i]) begin
                    g.found = 1'b1;
                    g.chan  = CH_W'(i);
                end
            end
            // round robin falls back to the least recently used entry
            if (!g.found && md == MODE_RR && pkt_len[s] > 0) begin
                g.found = 1'b1;
                g.chan  = pkt_order[s][0];
            end
        end
        if (g.found) begin
            case (md)
                MODE_CIRCUIT: circ_mask[s][g.chan] = 1'b1;
                MODE_FIRST:   list_push(s, g.chan);
                default: begin
                    list_drop(s, g.chan);
                    list_push(s, g.chan);
                end
            endcase
        end
        return g;
    endfunction

    always @(posedge i_clk) begin
        t_grant want;
        if (!i_rst_n) begin
            for (int s = 0; s < 2; s++) begin
                chan_limit[s] = CFG_COUNT_RESET;
                circ_mask[s]  = '0;
                pkt_len[s]    = 0;
                for (int k = 0; k < LIST_DEPTH; k++) pkt_order[s][k] = '0;
            end
            pending_grants.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_PROD_COUNT) chan_limit[SIDE_PROD] = i_cfg_data;
                else if (i_cfg_index == CFG_CONS_COUNT) chan_limit[SIDE_CONS] = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_grants.size() == 0) begin
                    $error("result beat with no request outstanding: found %0d chan %0d",
                           i_found, i_chosen_channel);
                    o_fail_count++;
                end else begin
                    want = pending_grants.pop_front();
                    if (i_found !== want.found) begin
                        $error("found: expected %0d, actual %0d", want.found, i_found);
                        o_fail_count++;
                    end
                    if (i_chosen_channel !== want.chan) begin
                        $error("chosen_channel: expected %0d, actual %0d",
                               want.chan, i_chosen_channel);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                pending_grants.push_back(allocate(i_command, i_side, i_mode,
                                                  i_given_channel));
        end
        o_pending = pending_grants.size();
    end

endmodule

// File: dv/dma_channel_allocator_lru_top_test.sv
`timescale 1ns / 1ps
// Top of the DMA channel allocator testbench: clock, reset, request and register stimulus,
// result back-pressure and verdict. Depends on dca_pkg, dca_checker and the allocator top.
module dma_channel_allocator_lru_top_test import dca_pkg::*;;

    localparam int CYCLE_LIMIT = 400_000;   // far above the slowest legal run
    localparam int SETTLE      = 24;        // above the worst round-robin latency
    localparam int SEGMENTS    = 6;
    localparam int SEG_ITEMS   = 275;
    // register indexes the block does not decode; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(15);

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_command;
    logic                  i_side;
    logic [1:0]            i_mode;
    logic [CH_W-1:0]       i_given_channel;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_found;
    logic [CH_W-1:0]       o_chosen_channel;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int fail_count;
    int pending;
    int cycle_count;
    int send_idle_pct;
    int recv_idle_pct;

    // Channel counts per random segment: covers zero, one, the top of range
    // and values above the channel reach (clamped to eight inside the block).
    logic [CFG_DATA_W-1:0] prod_setting [SEGMENTS] = '{4'd3, 4'd8, 4'd0, 4'd5, 4'd15, 4'd1};
    logic [CFG_DATA_W-1:0] cons_setting [SEGMENTS] = '{4'd1, 4'd8, 4'd15, 4'd2, 4'd0, 4'd6};

    always #5 i_clk = ~i_clk;

    dma_channel_allocator_lru_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_side           (i_side),
        .i_mode           (i_mode),
        .i_given_channel  (i_given_channel),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_found          (o_found),
        .o_chosen_channel (o_chosen_channel),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    dca_checker grant_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_side           (i_side),
        .i_mode           (i_mode),
        .i_given_channel  (i_given_channel),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_found          (o_found),
        .i_chosen_channel (o_chosen_channel),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // Result back-pressure, redrawn every falling edge.
    always @(negedge i_clk) begin
        i_out_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("dma_channel_allocator_lru_top_test: errors");
        $finish;
    end

    // One request beat. Entered and left at a falling edge; valid stays high
    // on return so back-to-back beats keep it up without a drop.
    task automatic send_request(logic cmd, logic sd, logic [1:0] md, logic [CH_W-1:0] given);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      = 1'b1;
        i_command       = cmd;
        i_side          = sd;
        i_mode          = md;
        i_given_channel = given;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stop sending, let every grant come back, then give the block time to
    // settle before anything touches its registers.
    task automatic drain();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Random request: finds dominate; explicit circuit assigns are thinned
    // out since they fill the circuit mask for good.
    task automatic random_request();
        logic       cmd;
        logic [1:0] md;
        int         r;
        cmd = ($urandom_range(99) < 20) ? CMD_ASSIGN : CMD_FIND;
        r   = $urandom_range(99);
        md  = (r < 10) ? MODE_UNUSED : (r < 35) ? MODE_CIRCUIT : (r < 65) ? MODE_FIRST : MODE_RR;
        if (cmd == CMD_ASSIGN && md == MODE_CIRCUIT && $urandom_range(2) != 0) md = MODE_RR;
        send_request(cmd, 1'($urandom_range(1)), md, CH_W'($urandom_range(7)));
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_command       = CMD_FIND;
        i_side          = SIDE_PROD;
        i_mode          = MODE_CIRCUIT;
        i_given_channel = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_PROD_COUNT;
        i_cfg_data      = '0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // ---- directed: reset counts of two ----
        send_request(CMD_FIND,   SIDE_PROD, MODE_CIRCUIT, 3'd0);  // takes 0
        send_request(CMD_FIND,   SIDE_PROD, MODE_UNUSED,  3'd0);  // unused mode: nothing
        send_request(CMD_ASSIGN, SIDE_CONS, MODE_UNUSED,  3'd7);  // unused even for assign
        send_request(CMD_FIND,   SIDE_PROD, MODE_CIRCUIT, 3'd0);  // takes 1
        send_request(CMD_FIND,   SIDE_PROD, MODE_CIRCUIT, 3'd0);  // nothing free
        send_request(CMD_FIND,   SIDE_PROD, MODE_FIRST,   3'd0);  // nothing outside circuit
        send_request(CMD_FIND,   SIDE_PROD, MODE_RR,      3'd0);  // empty list: nothing
        send_request(CMD_ASSIGN, SIDE_PROD, MODE_CIRCUIT, 3'd7);  // above the count, taken
        send_request(CMD_ASSIGN, SIDE_PROD, MODE_FIRST,   3'd5);  // list [5]
        send_request(CMD_FIND,   SIDE_PROD, MODE_RR,      3'd0);  // reuses oldest, 5
        send_request(CMD_ASSIGN, SIDE_PROD, MODE_RR,      3'd6);  // list [5 6]
        send_request(CMD_FIND,   SIDE_PROD, MODE_RR,      3'd0);  // 5 again, list [6 5]
        drain();

        // zero count on producer, consumer above the channel reach
        write_register(CFG_PROD_COUNT, 4'd0);
        write_register(CFG_CONS_COUNT, 4'd15);
        write_register(CFG_SPARE_HI, 4'd15);
        send_request(CMD_FIND,   SIDE_PROD, MODE_CIRCUIT, 3'd0);  // zero count: nothing
        send_request(CMD_FIND,   SIDE_CONS, MODE_FIRST,   3'd0);  // 0 into list
        send_request(CMD_FIND,   SIDE_CONS, MODE_FIRST,   3'd0);  // 0 again, list unchanged
        send_request(CMD_FIND,   SIDE_CONS, MODE_CIRCUIT, 3'd0);  // 1, skips listed 0
        send_request(CMD_FIND,   SIDE_CONS, MODE_RR,      3'd0);  // 2, list [0 2]
        send_request(CMD_ASSIGN, SIDE_CONS, MODE_FIRST,   3'd0);  // already listed
        for (int c = 3; c < LIST_DEPTH; c++)
            send_request(CMD_ASSIGN, SIDE_CONS, MODE_RR, CH_W'(c));
        send_request(CMD_FIND,   SIDE_CONS, MODE_RR,      3'd0);  // all taken: rotate 0
        send_request(CMD_ASSIGN, SIDE_CONS, MODE_FIRST,   3'd1);  // list full at eight
        send_request(CMD_FIND,   SIDE_CONS, MODE_RR,      3'd0);  // rotate oldest, 2
        drain();

        // ---- random: two segments per back-pressure profile ----
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg / 2)
                0: begin send_idle_pct = 27; recv_idle_pct = 49; end
                1: begin send_idle_pct = 49; recv_idle_pct = 27; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            write_register(CFG_PROD_COUNT, prod_setting[seg]);
            write_register(CFG_CONS_COUNT, cons_setting[seg]);
            write_register(CFG_IDX_W'($urandom_range(CFG_SPARE_HI, CFG_SPARE_LO)),
                           CFG_DATA_W'($urandom_range(15)));
            for (int n = 0; n < SEG_ITEMS; n++) random_request();
            drain();
        end

        if (fail_count == 0) begin
            $display("dma_channel_allocator_lru_top_test: clean");
        end else begin
            $display("dma_channel_allocator_lru_top_test: errors");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/dca_pkg.sv
hw/rtl/dca_cell.sv
hw/rtl/dca_chain.sv
hw/rtl/dma_channel_allocator_lru_top.sv
dv/dca_checker.sv
dv/dma_channel_allocator_lru_top_test.sv
